// ===== hdl/cst_pkg.sv =====
package cst_pkg;

	// Table geometry default
	localparam int TABLE_DEPTH_DEF = 16;

	// Field widths
	localparam int ID_W   = 31;
	localparam int HND_W  = 16;
	localparam int IP_W   = 32;
	localparam int PORT_W = 16;
	localparam int IDX_W  = 4;

	localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
	localparam logic [ID_W-1:0] ID_MAX   = {ID_W{1'b1}};

	// Action codes
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_FIND   = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_EXISTS = 2'd3
	} action_t;

	// Controller states, one-hot
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture a new transaction
		logic step;    // issue next slot read
		logic commit;  // apply update and present result
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic done;    // scan reached a hit or its last slot
	} stat_t;

endpackage

// ===== hdl/cst_ctrl.sv =====
module cst_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  cst_pkg::stat_t stat,
	output cst_pkg::cmd_t  cmd,
	output logic           busy
);

	cst_pkg::state_t state_q;
	cst_pkg::state_t state_d;

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			cst_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = cst_pkg::ST_SCAN;
				end
			end
			cst_pkg::ST_SCAN: begin
				cmd.step = 1'b1;
				if (stat.done) begin
					cmd.commit = 1'b1;
					state_d    = cst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cst_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != cst_pkg::ST_IDLE);

endmodule

// ===== hdl/cst_dp.sv =====
module cst_dp #(
	parameter int TABLE_DEPTH = cst_pkg::TABLE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cst_pkg::cmd_t              cmd,
	output cst_pkg::stat_t             stat,
	input  logic [1:0]                 action,
	input  logic [cst_pkg::HND_W-1:0]  handle,
	input  logic [cst_pkg::IP_W-1:0]   ip_addr,
	input  logic [cst_pkg::PORT_W-1:0] port,
	input  logic [cst_pkg::ID_W-1:0]   conn_id,
	input  logic [cst_pkg::IDX_W-1:0]  slot_index,
	output logic                       done,
	output logic                       success,
	output logic [cst_pkg::ID_W-1:0]   result_id,
	output logic [cst_pkg::IDX_W-1:0]  result_index,
	output logic [cst_pkg::HND_W-1:0]  released_handle
);

	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

	// Slot storage
	logic [cst_pkg::ID_W-1:0]   id_mem   [TABLE_DEPTH];
	logic [cst_pkg::HND_W-1:0]  hnd_mem  [TABLE_DEPTH];
	logic [cst_pkg::IP_W-1:0]   ip_mem   [TABLE_DEPTH];
	logic [cst_pkg::PORT_W-1:0] port_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]     valid_q;
	logic [cst_pkg::ID_W-1:0]   next_id_q;

	// Captured transaction
	cst_pkg::action_t           act_q;
	logic [cst_pkg::HND_W-1:0]  hnd_q;
	logic [cst_pkg::IP_W-1:0]   ip_q;
	logic [cst_pkg::PORT_W-1:0] port_q;
	logic [cst_pkg::ID_W-1:0]   cid_q;
	logic [cst_pkg::IDX_W-1:0]  sidx_q;

	// Scan address and read stage
	logic [ADDR_W-1:0]          addr_q;
	logic                       issuing_q;
	logic                       vld_s1;
	logic [ADDR_W-1:0]          idx_s1;
	logic [cst_pkg::ID_W-1:0]   id_s1;
	logic [cst_pkg::HND_W-1:0]  hnd_s1;
	logic [cst_pkg::IP_W-1:0]   ip_s1;
	logic [cst_pkg::PORT_W-1:0] port_s1;

	logic is_remove;
	logic last_s1;
	logic slot_vld;
	logic in_range;
	logic hit;

	assign is_remove = (act_q == cst_pkg::ACT_REMOVE);
	assign slot_vld  = valid_q[idx_s1];
	assign in_range  = (32'(sidx_q) < 32'(TABLE_DEPTH));
	assign last_s1   = is_remove || (idx_s1 == LAST_ADDR);

	// Per-action match on the slot in the read stage
	always_comb begin
		unique case (act_q)
			cst_pkg::ACT_INSERT: hit = !slot_vld;
			cst_pkg::ACT_FIND:   hit = slot_vld && (id_s1 == cid_q);
			cst_pkg::ACT_REMOVE: hit = slot_vld && in_range;
			cst_pkg::ACT_EXISTS: hit = slot_vld && (ip_s1 == ip_q) && (port_s1 == port_q);
			default:             hit = 1'b0;
		endcase
	end

	assign stat.done = vld_s1 && (hit || last_s1);

	// Transaction capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= cst_pkg::action_t'(action);
			hnd_q  <= handle;
			ip_q   <= ip_addr;
			port_q <= port;
			cid_q  <= conn_id;
			sidx_q <= slot_index;
		end
	end

	// Scan sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			issuing_q <= 1'b0;
			vld_s1    <= 1'b0;
		end else if (cmd.load) begin
			addr_q    <= (cst_pkg::action_t'(action) == cst_pkg::ACT_REMOVE) ?
			             ADDR_W'(slot_index) : '0;
			issuing_q <= 1'b1;
			vld_s1    <= 1'b0;
		end else if (cmd.step) begin
			vld_s1 <= issuing_q;
			if (issuing_q) begin
				if (is_remove || (addr_q == LAST_ADDR)) begin
					issuing_q <= 1'b0;
				end else begin
					addr_q <= addr_q + ADDR_W'(1);
				end
			end
		end
	end

	// Slot memories: one registered read, one write on a successful insert commit
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			idx_s1  <= addr_q;
			id_s1   <= id_mem[addr_q];
			hnd_s1  <= hnd_mem[addr_q];
			ip_s1   <= ip_mem[addr_q];
			port_s1 <= port_mem[addr_q];
		end
		if (cmd.commit && hit && (act_q == cst_pkg::ACT_INSERT)) begin
			id_mem[idx_s1]   <= next_id_q;
			hnd_mem[idx_s1]  <= hnd_q;
			ip_mem[idx_s1]   <= ip_q;
			port_mem[idx_s1] <= port_q;
		end
	end

	// Valid marks and id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			next_id_q <= cst_pkg::ID_FIRST;
		end else if (cmd.commit && hit) begin
			if (act_q == cst_pkg::ACT_INSERT) begin
				valid_q[idx_s1] <= 1'b1;
				next_id_q <= (next_id_q == cst_pkg::ID_MAX) ? cst_pkg::ID_FIRST :
				             next_id_q + cst_pkg::ID_W'(1);
			end else if (act_q == cst_pkg::ACT_REMOVE) begin
				valid_q[idx_s1] <= 1'b0;
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.commit;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			success         <= hit;
			result_id       <= '0;
			result_index    <= '0;
			released_handle <= '0;
			if (hit) begin
				unique case (act_q)
					cst_pkg::ACT_INSERT: begin
						result_id    <= next_id_q;
						result_index <= cst_pkg::IDX_W'(idx_s1);
					end
					cst_pkg::ACT_FIND: begin
						result_index <= cst_pkg::IDX_W'(idx_s1);
					end
					cst_pkg::ACT_REMOVE: begin
						released_handle <= hnd_s1;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ===== hdl/connection_slot_table_top.sv =====
// Channel   Handshake                 Payload
// input     start / busy              action, handle, ip_addr, port, conn_id, slot_index
// result    done (one-cycle strobe)   success, result_id, result_index, released_handle
//
// A transaction is accepted at an edge with start high and busy low.
// Insert, find and exists scan the slots one per cycle through a registered
// read of the slot memory and commit at the first hit, or after the last slot
// on a miss. Remove reads only the slot given by slot_index and commits.
// done shows the result in the cycle after commit, when busy is already low.
// Reset clears all valid marks at once and sets the id counter to 1.
// The receiver cannot stall; each result is shown for one cycle only.
module connection_slot_table_top #(
	parameter int TABLE_DEPTH = cst_pkg::TABLE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 action,
	input  logic [cst_pkg::HND_W-1:0]  handle,
	input  logic [cst_pkg::IP_W-1:0]   ip_addr,
	input  logic [cst_pkg::PORT_W-1:0] port,
	input  logic [cst_pkg::ID_W-1:0]   conn_id,
	input  logic [cst_pkg::IDX_W-1:0]  slot_index,
	output logic                       done,
	output logic                       success,
	output logic [cst_pkg::ID_W-1:0]   result_id,
	output logic [cst_pkg::IDX_W-1:0]  result_index,
	output logic [cst_pkg::HND_W-1:0]  released_handle
);

	cst_pkg::cmd_t  cmd;
	cst_pkg::stat_t stat;

	cst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	cst_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.action          (action),
		.handle          (handle),
		.ip_addr         (ip_addr),
		.port            (port),
		.conn_id         (conn_id),
		.slot_index      (slot_index),
		.done            (done),
		.success         (success),
		.result_id       (result_id),
		.result_index    (result_index),
		.released_handle (released_handle)
	);

endmodule

// ===== hdl/cst_chk.sv =====
module cst_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic                       success,
	input logic [cst_pkg::ID_W-1:0]   result_id,
	input logic [cst_pkg::HND_W-1:0]  released_handle
);

	// An accepted transaction keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	// Result is shown only once the block is idle again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// Every completed transaction yields a result when busy falls
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("transaction ended without result");

	// An assigned id implies a successful insert
	a_id_success: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result_id != '0) |-> success && (released_handle == '0))
		else $error("id reported without success");

	// A released handle implies a successful remove
	a_hnd_success: assert property (@(posedge clk) disable iff (!arst_n)
		done && (released_handle != '0) |-> success && (result_id == '0))
		else $error("handle reported without success");

endmodule

bind connection_slot_table_top cst_chk u_cst_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.success         (success),
	.result_id       (result_id),
	.released_handle (released_handle)
);
